@@ rtl/kvlp_pkg.sv @@
// Shared codes, character constants and the step result type of the line parser.
package kvlp_pkg;

  // Parse modes
  localparam logic [2:0] M_START  = 3'd0;
  localparam logic [2:0] M_KEY    = 3'd1;
  localparam logic [2:0] M_EQUAL  = 3'd2;
  localparam logic [2:0] M_NUMBER = 3'd3;
  localparam logic [2:0] M_STRING = 3'd4;
  localparam logic [2:0] M_CLOSED = 3'd5;
  localparam logic [2:0] M_DROP   = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Line status codes
  localparam logic [3:0] ST_EMPTY   = 4'd0;
  localparam logic [3:0] ST_STRING  = 4'd1;
  localparam logic [3:0] ST_NUMBER  = 4'd2;
  localparam logic [3:0] ST_QUOTE   = 4'd3;
  localparam logic [3:0] ST_EQUAL   = 4'd4;
  localparam logic [3:0] ST_DIGIT   = 4'd5;
  localparam logic [3:0] ST_DATA    = 4'd6;
  localparam logic [3:0] ST_NOKEY   = 4'd7;
  localparam logic [3:0] ST_NOVALUE = 4'd8;
  localparam logic [3:0] ST_UNTERM  = 4'd9;
  localparam logic [3:0] ST_KEYLONG = 4'd10;
  localparam logic [3:0] ST_VALLONG = 4'd11;

  // Characters with a special meaning
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Result of one parse step
  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] status;
  } step_res_t;

endpackage

@@ rtl/kvlp_step.sv @@
// Per-byte decode and next-state logic of the line parser.
module kvlp_step #(
  parameter int KEY_MAX_CHARS   = 63,
  parameter int VALUE_MAX_CHARS = 63,
  localparam int KCW = ($clog2(KEY_MAX_CHARS + 1) > 6) ? $clog2(KEY_MAX_CHARS + 1) : 6,
  localparam int VCW = ($clog2(VALUE_MAX_CHARS + 1) > 6) ? $clog2(VALUE_MAX_CHARS + 1) : 6
) (
  input  logic [7:0]        byte_in,
  input  logic [2:0]        mode,
  input  logic [KCW-1:0]    kcnt,
  input  logic [VCW-1:0]    vcnt,
  input  logic              cmt,
  output logic [2:0]        mode_nxt,
  output logic [KCW-1:0]    kcnt_nxt,
  output logic [VCW-1:0]    vcnt_nxt,
  output logic              cmt_nxt,
  output kvlp_pkg::step_res_t res
);
  import kvlp_pkg::*;

  logic       instr;
  logic       is_word;
  logic       is_digit;
  logic       do_key;
  logic       do_value;
  logic       do_fail;
  logic [3:0] fail_code;
  logic [3:0] end_code;

  // Classify the byte
  assign instr    = (mode == M_STRING);
  assign is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
  assign is_word  = ((byte_in >= 8'h61) && (byte_in <= 8'h7A)) ||
                    ((byte_in >= 8'h41) && (byte_in <= 8'h5A)) ||
                    (byte_in == CH_DOT) || (byte_in == CH_UNDER);

  // Judge the line at its end
  always_comb begin
    if (mode == M_START) begin
      end_code = ST_EMPTY;
    end else if (kcnt == '0) begin
      end_code = ST_NOKEY;
    end else if (vcnt == '0) begin
      end_code = ST_NOVALUE;
    end else if (mode == M_NUMBER) begin
      end_code = ST_NUMBER;
    end else if (mode == M_CLOSED) begin
      end_code = ST_STRING;
    end else begin
      end_code = ST_UNTERM;
    end
  end

  // Advance the mode and pick the result
  always_comb begin
    mode_nxt  = mode;
    kcnt_nxt  = kcnt;
    vcnt_nxt  = vcnt;
    cmt_nxt   = cmt;
    res       = '{emit: 1'b0, kind: KIND_STATUS, ch: 8'h00, status: ST_EMPTY};
    do_key    = 1'b0;
    do_value  = 1'b0;
    do_fail   = 1'b0;
    fail_code = ST_EMPTY;

    if ((byte_in == CH_LF) || (byte_in == CH_NUL)) begin
      // Close the line: report unless already reported, then clear
      if (mode != M_DROP) begin
        res.emit   = 1'b1;
        res.status = end_code;
      end
      mode_nxt = M_START;
      kcnt_nxt = '0;
      vcnt_nxt = '0;
      cmt_nxt  = 1'b0;
    end else if ((mode != M_DROP) && !cmt) begin
      if (byte_in == CH_HASH) begin
        if (instr) do_value = 1'b1;
        else cmt_nxt = 1'b1;
      end else if ((byte_in == CH_SPACE) || (byte_in == CH_TAB)) begin
        if (instr) do_value = 1'b1;
      end else if (byte_in == CH_QUOTE) begin
        if (instr) begin
          mode_nxt = M_CLOSED;
        end else if (mode == M_EQUAL) begin
          mode_nxt = M_STRING;
        end else begin
          do_fail   = 1'b1;
          fail_code = ST_QUOTE;
        end
      end else if (byte_in == CH_EQUAL) begin
        if (mode == M_KEY) begin
          mode_nxt = M_EQUAL;
        end else if (instr) begin
          do_value = 1'b1;
        end else begin
          do_fail   = 1'b1;
          fail_code = ST_EQUAL;
        end
      end else if (is_digit) begin
        if (mode == M_EQUAL) begin
          mode_nxt = M_NUMBER;
          do_value = 1'b1;
        end else if ((mode == M_NUMBER) || instr) begin
          do_value = 1'b1;
        end else begin
          do_fail   = 1'b1;
          fail_code = ST_DIGIT;
        end
      end else if (is_word) begin
        if (mode == M_START) begin
          mode_nxt = M_KEY;
          do_key   = 1'b1;
        end else if (mode == M_KEY) begin
          do_key = 1'b1;
        end else if (instr) begin
          do_value = 1'b1;
        end else begin
          do_fail   = 1'b1;
          fail_code = ST_DATA;
        end
      end

      // Take a key character or flag an overlong key
      if (do_key) begin
        if (kcnt >= KCW'(KEY_MAX_CHARS)) begin
          do_fail   = 1'b1;
          fail_code = ST_KEYLONG;
        end else begin
          kcnt_nxt = kcnt + KCW'(1);
          res.emit = 1'b1;
          res.kind = KIND_KEY;
          res.ch   = byte_in;
        end
      end

      // Take a value character or flag an overlong value
      if (do_value) begin
        if (vcnt >= VCW'(VALUE_MAX_CHARS)) begin
          do_fail   = 1'b1;
          fail_code = ST_VALLONG;
        end else begin
          vcnt_nxt = vcnt + VCW'(1);
          res.emit = 1'b1;
          res.kind = KIND_VALUE;
          res.ch   = byte_in;
        end
      end

      // Report the error now and drop the rest of the line
      if (do_fail) begin
        mode_nxt   = M_DROP;
        res.emit   = 1'b1;
        res.status = fail_code;
      end
    end
  end

endmodule

@@ rtl/key_value_line_parser.sv @@
// Top level of the streaming key = value line parser.
// One text byte is taken per request and at most one result comes back for it: a key
// character, a value character, or the line status. The block sustains one byte per
// cycle unless the output stalls; a byte is registered on entry, decoded and parsed
// in the next cycle against the mode and length counters, and its result is
// registered on the output. The input stalls only while a byte that yields a result
// waits behind a stalled output. Bytes that produce no result still pass through the
// parse cycle. Line feed and NUL end a line; an error is reported as soon as it is seen,
// after which the rest of the line yields nothing. Lengths are reported in their low
// six bits; a status carries the counts gathered on the line up to that point.
module key_value_line_parser #(
  parameter int KEY_MAX_CHARS   = 63,
  parameter int VALUE_MAX_CHARS = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_char_out,
  output logic [3:0] out_line_status,
  output logic [5:0] out_key_length,
  output logic [5:0] out_value_length
);
  import kvlp_pkg::*;

  localparam int KCW = ($clog2(KEY_MAX_CHARS + 1) > 6) ? $clog2(KEY_MAX_CHARS + 1) : 6;
  localparam int VCW = ($clog2(VALUE_MAX_CHARS + 1) > 6) ? $clog2(VALUE_MAX_CHARS + 1) : 6;

  logic           s1_valid_r;
  logic [7:0]     s1_byte_r;
  logic [2:0]     mode_r;
  logic [2:0]     mode_nxt;
  logic [KCW-1:0] kcnt_r;
  logic [KCW-1:0] kcnt_nxt;
  logic [VCW-1:0] vcnt_r;
  logic [VCW-1:0] vcnt_nxt;
  logic           cmt_r;
  logic           cmt_nxt;
  step_res_t      res;
  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic [7:0]     out_ch_r;
  logic [3:0]     out_status_r;
  logic [5:0]     out_klen_r;
  logic [5:0]     out_vlen_r;
  logic           out_free;
  logic           s1_adv;
  logic           in_take;

  kvlp_step #(
    .KEY_MAX_CHARS  (KEY_MAX_CHARS),
    .VALUE_MAX_CHARS(VALUE_MAX_CHARS)
  ) u_step (
    .byte_in (s1_byte_r),
    .mode    (mode_r),
    .kcnt    (kcnt_r),
    .vcnt    (vcnt_r),
    .cmt     (cmt_r),
    .mode_nxt(mode_nxt),
    .kcnt_nxt(kcnt_nxt),
    .vcnt_nxt(vcnt_nxt),
    .cmt_nxt (cmt_nxt),
    .res     (res)
  );

  // Advance the held byte when its result has room or it yields none
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!res.emit || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_text_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      kcnt_r <= '0;
      vcnt_r <= '0;
      cmt_r  <= 1'b0;
    end else if (s1_adv) begin
      mode_r <= mode_nxt;
      kcnt_r <= kcnt_nxt;
      vcnt_r <= vcnt_nxt;
      cmt_r  <= cmt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold status counts at their values before the line end clears them
  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_kind_r   <= res.kind;
      out_ch_r     <= res.ch;
      out_status_r <= res.status;
      out_klen_r   <= (res.kind == KIND_STATUS) ? kcnt_r[5:0] : kcnt_nxt[5:0];
      out_vlen_r   <= (res.kind == KIND_STATUS) ? vcnt_r[5:0] : vcnt_nxt[5:0];
    end
  end

  // Drive the result ports from the result register
  assign out_valid        = out_valid_r;
  assign out_item_kind    = out_kind_r;
  assign out_char_out     = out_ch_r;
  assign out_line_status  = out_status_r;
  assign out_key_length   = out_klen_r;
  assign out_value_length = out_vlen_r;

`ifndef SYNTH
  // A status result carries no character
  a_status_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_STATUS) |-> out_char_out == 8'h00)
    else $error("status result with a character");

  // Key characters come before any value character
  a_key_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_KEY) |-> out_value_length == 6'd0)
    else $error("key character after value characters");

  // A line end clears the parser state
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && ((s1_byte_r == CH_LF) || (s1_byte_r == CH_NUL))
    |=> (mode_r == M_START) && (kcnt_r == '0) && (vcnt_r == '0) && !cmt_r)
    else $error("state not cleared at line end");

  // Stall only while a byte waits on a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && res.emit && out_valid_r && out_stall)
    else $error("input stalled without cause");
`endif

endmodule

@@ tb/key_value_line_parser_checker.sv @@
// Checker for the key = value line parser: predicts each request's result and compares.
module key_value_line_parser_checker #(
  parameter int KEY_MAX_CHARS   = 63,
  parameter int VALUE_MAX_CHARS = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_item_kind,
  input  logic [7:0] out_char_out,
  input  logic [3:0] out_line_status,
  input  logic [5:0] out_key_length,
  input  logic [5:0] out_value_length,
  output int         mismatches,
  output int         pending
);
  import kvlp_pkg::*;

  localparam logic [3:0] NO_STATUS = 4'd0;
  localparam logic [7:0] NO_CHAR   = 8'h00;
  localparam int MAX_PRINTED       = 200;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] status;
    logic [5:0] key_len;
    logic [5:0] val_len;
  } parse_item_t;

  parse_item_t expected_items[$];

  // Predicted parser state
  logic [2:0] mode;
  int         key_cnt;
  int         val_cnt;
  logic       in_comment;
  int         fail_count = 0;

  function automatic void restart_line();
    mode       = M_START;
    key_cnt    = 0;
    val_cnt    = 0;
    in_comment = 1'b0;
  endfunction

  function automatic parse_item_t make_item(logic [1:0] kind, logic [7:0] ch,
                                            logic [3:0] status);
    parse_item_t r;
    r.kind    = kind;
    r.ch      = ch;
    r.status  = status;
    r.key_len = key_cnt[5:0];
    r.val_len = val_cnt[5:0];
    return r;
  endfunction

  // Report the error now and drop the rest of the line
  function automatic parse_item_t reject_line(logic [3:0] status);
    mode = M_DROP;
    return make_item(KIND_STATUS, NO_CHAR, status);
  endfunction

  function automatic parse_item_t add_key_char(logic [7:0] c);
    if (key_cnt >= KEY_MAX_CHARS) return reject_line(ST_KEYLONG);
    key_cnt++;
    return make_item(KIND_KEY, c, NO_STATUS);
  endfunction

  function automatic parse_item_t add_value_char(logic [7:0] c);
    if (val_cnt >= VALUE_MAX_CHARS) return reject_line(ST_VALLONG);
    val_cnt++;
    return make_item(KIND_VALUE, c, NO_STATUS);
  endfunction

  function automatic logic [3:0] line_end_status();
    if (mode == M_START) return ST_EMPTY;
    if (key_cnt == 0) return ST_NOKEY;
    if (val_cnt == 0) return ST_NOVALUE;
    if (mode == M_NUMBER) return ST_NUMBER;
    if (mode == M_CLOSED) return ST_STRING;
    return ST_UNTERM;
  endfunction

  // Advance the predicted parser by one byte; return 1 when it yields a result
  function automatic bit parse_byte(input logic [7:0] c, output parse_item_t r);
    logic in_str;
    logic is_word;
    logic is_digit;
    bit   emit;
    r = '0;
    if (c == CH_LF || c == CH_NUL) begin
      emit = (mode != M_DROP);
      if (emit) r = make_item(KIND_STATUS, NO_CHAR, line_end_status());
      restart_line();
      return emit;
    end
    if (mode == M_DROP || in_comment) return 1'b0;

    in_str   = (mode == M_STRING);
    is_word  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == CH_DOT || c == CH_UNDER;
    is_digit = (c >= "0" && c <= "9");

    if (c == CH_HASH) begin
      if (in_str) begin
        r = add_value_char(c);
        return 1'b1;
      end
      in_comment = 1'b1;
      return 1'b0;
    end
    if (c == CH_SPACE || c == CH_TAB) begin
      if (!in_str) return 1'b0;
      r = add_value_char(c);
      return 1'b1;
    end
    if (c == CH_QUOTE) begin
      if (in_str) begin
        mode = M_CLOSED;
        return 1'b0;
      end
      if (mode == M_EQUAL) begin
        mode = M_STRING;
        return 1'b0;
      end
      r = reject_line(ST_QUOTE);
      return 1'b1;
    end
    if (c == CH_EQUAL) begin
      if (mode == M_KEY) begin
        mode = M_EQUAL;
        return 1'b0;
      end
      if (in_str) r = add_value_char(c);
      else r = reject_line(ST_EQUAL);
      return 1'b1;
    end
    if (is_digit) begin
      if (mode == M_EQUAL) mode = M_NUMBER;
      if (mode == M_NUMBER || in_str) r = add_value_char(c);
      else r = reject_line(ST_DIGIT);
      return 1'b1;
    end
    if (is_word) begin
      if (mode == M_START) mode = M_KEY;
      if (mode == M_KEY) r = add_key_char(c);
      else if (in_str) r = add_value_char(c);
      else r = reject_line(ST_DATA);
      return 1'b1;
    end
    // Any other byte class is ignored
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // Compare results against the oldest prediction, then predict for the new request
  always @(posedge clk) begin : watch
    parse_item_t want;
    parse_item_t pred;
    bit          emit;
    if (!rst_n) begin
      restart_line();
      expected_items.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_items.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d char %02h status %0d",
                                    out_item_kind, out_char_out, out_line_status));
        end else begin
          want = expected_items.pop_front();
          check_field("kind", out_item_kind, want.kind);
          check_field("char", out_char_out, want.ch);
          check_field("status", out_line_status, want.status);
          check_field("key length", out_key_length, want.key_len);
          check_field("value length", out_value_length, want.val_len);
        end
      end
      if (in_valid && !in_stall) begin
        emit = parse_byte(in_text_byte, pred);
        if (emit) expected_items.push_back(pred);
      end
    end
    pending    <= expected_items.size();
    mismatches <= fail_count;
  end

endmodule

@@ tb/key_value_line_parser_tb.sv @@
// Testbench top for the key = value line parser: stimulus, flow control and verdict.
module key_value_line_parser_tb;
  import kvlp_pkg::*;

  localparam int RANDOM_BYTES = 500;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 2000;

  logic       clk;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte     = 8'h00;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [1:0] out_item_kind;
  logic [7:0] out_char_out;
  logic [3:0] out_line_status;
  logic [5:0] out_key_length;
  logic [5:0] out_value_length;

  int         mismatches;
  int         pending;
  int         idle_run         = 0;
  int         directed_len;
  logic [7:0] text_q[$];

  key_value_line_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_kind    (out_item_kind),
    .out_char_out     (out_char_out),
    .out_line_status  (out_line_status),
    .out_key_length   (out_key_length),
    .out_value_length (out_value_length)
  );

  key_value_line_parser_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_kind    (out_item_kind),
    .out_char_out     (out_char_out),
    .out_line_status  (out_line_status),
    .out_key_length   (out_key_length),
    .out_value_length (out_value_length),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run = 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_run++;
    end
  end

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Build one line: mostly well-formed with random content, some broken, some noise
  function automatic void add_random_line(input bit long_key, input bit long_val);
    logic [7:0] ln[$];
    int         n;
    int         pos;
    int         shape;
    bit         forced;
    forced = long_key || long_val;
    shape  = forced ? $urandom_range(15, 99) : $urandom_range(0, 99);
    if (shape < 10) begin
      n = $urandom_range(1, 10);
      repeat (n) ln.push_back(8'($urandom_range(1, 255)));
    end else if (shape < 15) begin
      // blank line or comment line
      if ($urandom_range(0, 1) == 1) begin
        ln.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) ln.push_back(8'($urandom_range(1, 255)));
      end
    end else begin
      n = long_key ? $urandom_range(64, 66) :
          ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
      repeat (n) ln.push_back(pick_char("abcxyzABCXYZ._"));
      repeat ($urandom_range(0, 2)) ln.push_back(pick_char(" \t"));
      ln.push_back(CH_EQUAL);
      repeat ($urandom_range(0, 2)) ln.push_back(pick_char(" \t"));
      n = long_val ? $urandom_range(64, 66) :
          ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
      if (shape < 55) begin
        repeat (n) ln.push_back(pick_char("0123456789"));
      end else begin
        ln.push_back(CH_QUOTE);
        repeat (n) ln.push_back(pick_char("azAZ09._=# \t!\177\200\377"));
        ln.push_back(CH_QUOTE);
      end
      repeat ($urandom_range(0, 2)) ln.push_back(pick_char(" \t"));
      if ($urandom_range(0, 4) == 0) begin
        ln.push_back(CH_HASH);
        repeat ($urandom_range(0, 5)) ln.push_back(8'($urandom_range(1, 255)));
      end
      // break about a quarter of the lines: cut short or insert a stray byte
      if (!forced && $urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, ln.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            while (ln.size() > pos) void'(ln.pop_back());
          end
          1: begin
            ln.insert(pos, pick_char("=\"#.9a \t"));
          end
          default: begin
            ln.insert(pos, 8'($urandom_range(1, 255)));
          end
        endcase
      end
    end
    ln.push_back(($urandom_range(0, 4) == 0) ? CH_NUL : CH_LF);
    foreach (ln[i]) text_q.push_back(ln[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver: random stall segments, plus one long hold-off to fill the block
  initial begin : receiver
    int seen;
    int seg_len;
    int stall_pct;
    bit held;
    seen = 0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && seen >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        seg_len = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        repeat (seg_len) begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
          if (in_valid && !in_stall) seen++;
        end
      end
    end
  end

  // Sender: directed lines, then random lines, offered in bursts with gaps
  initial begin : sender
    int idx;
    int burst;
    int gap;
    text_q.push_back(CH_NUL);
    push_text("A.z_=\"9 #\t\"\n");
    push_text("q=\3775#z\n");
    push_text("==\n");
    push_text("9\n");
    push_text("k=1x\n");
    directed_len = text_q.size();
    add_random_line(1'b1, 1'b0);
    add_random_line(1'b0, 1'b1);
    while (text_q.size() < directed_len + RANDOM_BYTES) add_random_line(1'b0, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idx   = 0;
    burst = 0;
    while (idx < text_q.size()) begin
      if (idx == directed_len || idx == PAUSE_AT) begin
        // hold off until every predicted result has come back
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        burst = $urandom_range(1, 24);
      end else if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      send_byte(text_q[idx]);
      idx++;
      burst--;
    end
    in_valid <= 1'b0;

    // Drain the remaining results, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
